/* design/sbb_pkg.sv */
// Shared types and constants for the separable box blur.
// Used by sbb_win_acc and separable_box_blur_top.
`default_nettype none
package sbb_pkg;

  localparam int CHAN_W    = 8;
  localparam int N_CHAN    = 4;
  localparam int PIX_W     = CHAN_W * N_CHAN;
  localparam int CHAN_MAX  = 255;
  localparam int OUT_POS_W = 10;
  localparam int OUT_W     = 56;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS  = 2'd2;

  typedef struct packed {
    logic dat_valid;
    logic dat_first;
    logic dat_last;
  } sbb_acc_ctl_t;

endpackage
`default_nettype wire

/* design/separable_box_blur_top.sv */
// Separable box blur with clamped edges, RGBA8 in and out, raster order.
// Uses sbb_pkg, sbb_ram (current input row, ring of row-blurred lines), sbb_win_acc.
//
// An item that causes no work passes through only the transfer and the
// readiness check. A push that completes a window column costs one row-pass
// column (2r+1 reads of the row RAM, the registered read, a divide of eight
// quotient bits and a write); the last pixel of a row runs up to r+1 such
// columns. An item that releases an output adds one column pass over the
// line ring, plus any wait for the output register to be taken. Each of the
// two RAMs has a single read port, so the reads of a pass are issued one by
// one. Outputs carry their column and row; tlast marks the last pixel of the
// frame. A configuration write to frame width, frame height or blur radius
// restarts the frame.
`default_nettype none
module separable_box_blur_top
  import sbb_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [PIX_W-1:0]     s_tdata,   // in_red, in_green, in_blue, in_alpha
  input  wire logic [0:0]           s_tuser,   // command
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic      [OUT_W-1:0]     m_tdata,   // out_red, out_green, out_blue, out_alpha,
                                               // out_col, out_row, zero pad
  output logic                      m_tlast,   // frame_done
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int RING_ROWS = 2 * MAX_RADIUS + 2;
  localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RI  = $clog2(RING_ROWS);
  localparam int AW  = $clog2(RING_ROWS * MAX_WIDTH);
  localparam int KW  = $clog2(2 * MAX_RADIUS + 2);
  localparam int DW  = $clog2(2 * MAX_RADIUS + 2);
  localparam int SW  = $clog2(MAX_WIDTH + MAX_HEIGHT + 4 * MAX_RADIUS + 2052) + 1;
  localparam logic signed [SW-1:0] MW_S = SW'(MAX_WIDTH);
  localparam logic signed [SW-1:0] MH_S = SW'(MAX_HEIGHT);
  localparam logic signed [SW-1:0] MR_S = SW'(MAX_RADIUS);
  localparam logic signed [SW-1:0] ONE_S = SW'(1);
  localparam logic signed [SW-1:0] RING_S = SW'(RING_ROWS);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_HRD  = 8'b0000_0010,
    S_HDIV = 8'b0000_0100,
    S_HWR  = 8'b0000_1000,
    S_VCHK = 8'b0001_0000,
    S_VRD  = 8'b0010_0000,
    S_VDIV = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [4:0]       blur_radius;

  logic signed [SW-1:0] fw_s, fh_s, fr_s, w_e, h_e, r_e, wm1, hm1;

  logic [CW-1:0] in_col;
  logic [HW-1:0] in_row;
  logic [RI-1:0] in_ring;
  logic [CW-1:0] ecol;
  logic [RW-1:0] erow;
  logic [RI-1:0] e_ring;

  logic [CW-1:0] hx;
  logic [CW-1:0] hx_end;
  logic [RI-1:0] h_ring;
  logic [RI-1:0] v_ring;
  logic signed [SW-1:0] sraw;
  logic [KW-1:0] kcnt;

  logic iss_q, first_q, last_q, src_v_q;

  logic signed [SW-1:0] in_col_s, in_row_s, ecol_s, erow_s, hx_s;
  logic signed [SW-1:0] hx_start, hr, ny, nx, v_sum, ring_tmp, sn;
  logic [KW-1:0] klast;
  logic iss, iss_last, ready, push_eff, accept, out_load, frame_last;
  logic [RI-1:0] ring_start;

  logic [PIX_W-1:0] raw_rdata, ring_rdata, acc_quot;
  logic acc_done;
  sbb_acc_ctl_t acc_ctl;
  logic [DW-1:0] divisor;

  logic [CW+OUT_POS_W-1:0] ecol_wide;
  logic [RW+OUT_POS_W-1:0] erow_wide;

  always_comb begin
    fw_s = $signed(SW'(frame_width));
    fh_s = $signed(SW'(frame_height));
    fr_s = $signed(SW'(blur_radius));
    w_e  = (fw_s == '0) ? ONE_S : ((fw_s > MW_S) ? MW_S : fw_s);
    h_e  = (fh_s == '0) ? ONE_S : ((fh_s > MH_S) ? MH_S : fh_s);
    r_e  = (fr_s > MR_S) ? MR_S : fr_s;
    wm1  = w_e - ONE_S;
    hm1  = h_e - ONE_S;
  end

  assign divisor = DW'((r_e <<< 1) + ONE_S);
  assign klast   = KW'(r_e <<< 1);

  always_comb begin
    in_col_s = $signed(SW'(in_col));
    in_row_s = $signed(SW'(in_row));
    ecol_s   = $signed(SW'(ecol));
    erow_s   = $signed(SW'(erow));
    hx_s     = $signed(SW'(hx));
    if (in_col_s == wm1) begin
      hx_start = (wm1 >= r_e) ? (wm1 - r_e) : '0;
    end else begin
      hx_start = in_col_s - r_e;
    end
    hr = (sraw < 0) ? '0 : ((sraw > wm1) ? wm1 : sraw);
    v_sum = erow_s + r_e;
    ny = (v_sum > hm1) ? hm1 : v_sum;
    nx = ((ecol_s + r_e) > wm1) ? wm1 : (ecol_s + r_e);
    ready = (in_row_s > ny) || ((in_row_s == ny) && (in_col_s > nx));
    ring_tmp = $signed(SW'(e_ring)) - r_e;
    if (ring_tmp < 0) begin
      ring_tmp = ring_tmp + RING_S;
    end
    ring_start = (erow_s >= r_e) ? RI'(ring_tmp) : '0;
    sn = sraw + ONE_S;
  end

  assign s_tready   = (state == S_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign push_eff   = (s_tuser[0] == CMD_PUSH) && (in_row_s < h_e);
  assign iss        = (state == S_HRD) || (state == S_VRD);
  assign iss_last   = (kcnt == klast);
  assign out_load   = (state == S_OUT) && (!m_tvalid || m_tready);
  assign frame_last = (ecol_s == wm1) && (erow_s == hm1);

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_q <= 1'b0;
    end else begin
      iss_q <= iss;
    end
    first_q <= (kcnt == '0);
    last_q  <= iss_last;
    src_v_q <= (state == S_VRD);
  end

  assign acc_ctl.dat_valid = iss_q;
  assign acc_ctl.dat_first = first_q;
  assign acc_ctl.dat_last  = last_q;

  sbb_ram #(.DEPTH(MAX_WIDTH), .WIDTH(PIX_W)) u_raw_ram (
    .clk   (clk),
    .we    (accept && push_eff),
    .waddr (in_col),
    .wdata (s_tdata),
    .raddr (CW'(hr)),
    .rdata (raw_rdata)
  );

  sbb_ram #(.DEPTH(RING_ROWS * MAX_WIDTH), .WIDTH(PIX_W)) u_ring_ram (
    .clk   (clk),
    .we    (state == S_HWR),
    .waddr (AW'(h_ring) * AW'(MAX_WIDTH) + AW'(hx)),
    .wdata (acc_quot),
    .raddr (AW'(v_ring) * AW'(MAX_WIDTH) + AW'(ecol)),
    .rdata (ring_rdata)
  );

  sbb_win_acc #(.MAX_RADIUS(MAX_RADIUS)) u_win_acc (
    .clk     (clk),
    .rst     (rst),
    .ctl     (acc_ctl),
    .dat     (src_v_q ? ring_rdata : raw_rdata),
    .divisor (divisor),
    .done    (acc_done),
    .quot    (acc_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_width  <= CFG_W'(1024);
      frame_height <= CFG_W'(1024);
      blur_radius  <= 5'd16;
      in_col       <= '0;
      in_row       <= '0;
      in_ring      <= '0;
      ecol         <= '0;
      erow         <= '0;
      e_ring       <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT ||
                     cfg_index == CFG_BLUR_RADIUS)) begin
        case (cfg_index)
          CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
          CFG_FRAME_HEIGHT: frame_height <= cfg_data;
          default:          blur_radius  <= cfg_data[4:0];
        endcase
        in_col  <= '0;
        in_row  <= '0;
        in_ring <= '0;
        ecol    <= '0;
        erow    <= '0;
        e_ring  <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (push_eff) begin
              h_ring <= in_ring;
              hx     <= CW'(hx_start);
              sraw   <= hx_start - r_e;
              kcnt   <= '0;
              if (in_col_s == wm1) begin
                hx_end  <= CW'(wm1);
                in_col  <= '0;
                in_row  <= in_row + 1'b1;
                in_ring <= (in_ring == RI'(RING_ROWS - 1)) ? '0 : in_ring + 1'b1;
                state   <= S_HRD;
              end else begin
                hx_end <= CW'(hx_start);
                in_col <= in_col + 1'b1;
                state  <= (in_col_s >= r_e) ? S_HRD : S_VCHK;
              end
            end else begin
              state <= S_VCHK;
            end
          end
        end
        S_HRD: begin
          sraw <= sn;
          kcnt <= kcnt + 1'b1;
          if (iss_last) begin
            state <= S_HDIV;
          end
        end
        S_HDIV: begin
          if (acc_done && !iss_q) begin
            state <= S_HWR;
          end
        end
        S_HWR: begin
          if (hx == hx_end) begin
            state <= S_VCHK;
          end else begin
            hx    <= hx + 1'b1;
            sraw  <= hx_s + ONE_S - r_e;
            kcnt  <= '0;
            state <= S_HRD;
          end
        end
        S_VCHK: begin
          if (ready) begin
            sraw   <= erow_s - r_e;
            v_ring <= ring_start;
            kcnt   <= '0;
            state  <= S_VRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_VRD: begin
          sraw <= sn;
          kcnt <= kcnt + 1'b1;
          if ((sn >= ONE_S) && (sn <= hm1)) begin
            v_ring <= (v_ring == RI'(RING_ROWS - 1)) ? '0 : v_ring + 1'b1;
          end
          if (iss_last) begin
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (acc_done && !iss_q) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            if (frame_last) begin
              in_col  <= '0;
              in_row  <= '0;
              in_ring <= '0;
              ecol    <= '0;
              erow    <= '0;
              e_ring  <= '0;
            end else if (ecol_s == wm1) begin
              ecol   <= '0;
              erow   <= erow + 1'b1;
              e_ring <= (e_ring == RI'(RING_ROWS - 1)) ? '0 : e_ring + 1'b1;
            end else begin
              ecol <= ecol + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign ecol_wide = {{OUT_POS_W{1'b0}}, ecol};
  assign erow_wide = {{OUT_POS_W{1'b0}}, erow};

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {{(OUT_W - PIX_W - 2 * OUT_POS_W){1'b0}},
                  erow_wide[OUT_POS_W-1:0], ecol_wide[OUT_POS_W-1:0], acc_quot};
      m_tlast <= frame_last;
    end
  end

endmodule
`default_nettype wire

/* design/sbb_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module sbb_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/sbb_win_acc.sv */
// Window accumulator: sums four channels over a stream of pixels, then
// divides each sum by the window length one quotient bit a cycle. Uses sbb_pkg.
`default_nettype none
module sbb_win_acc
  import sbb_pkg::*;
#(
  parameter int MAX_RADIUS = 16,
  localparam int DW = $clog2(2 * MAX_RADIUS + 2)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire sbb_acc_ctl_t     ctl,
  input  wire logic [PIX_W-1:0] dat,
  input  wire logic [DW-1:0]    divisor,
  output logic                  done,
  output logic      [PIX_W-1:0] quot
);

  localparam int SUMW = $clog2(CHAN_MAX * (2 * MAX_RADIUS + 1) + 1);
  localparam int TW   = SUMW + CHAN_W;

  logic [SUMW-1:0]   acc [N_CHAN];
  logic [CHAN_W-1:0] q   [N_CHAN];
  logic [2:0]        step;
  logic              dividing;
  logic [TW-1:0]     trial;

  assign trial = TW'(divisor) << step;

  always_ff @(posedge clk) begin
    if (rst) begin
      dividing <= 1'b0;
      done     <= 1'b0;
      step     <= 3'd7;
    end else if (ctl.dat_valid) begin
      done <= 1'b0;
      if (ctl.dat_last) begin
        dividing <= 1'b1;
        step     <= 3'd7;
      end
    end else if (dividing) begin
      if (step == 3'd0) begin
        dividing <= 1'b0;
        done     <= 1'b1;
      end
      step <= step - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < N_CHAN; ch++) begin
      if (ctl.dat_valid) begin
        acc[ch] <= (ctl.dat_first ? SUMW'(0) : acc[ch]) + SUMW'(dat[ch*CHAN_W +: CHAN_W]);
        q[ch]   <= '0;
      end else if (dividing) begin
        if (TW'(acc[ch]) >= trial) begin
          acc[ch]     <= SUMW'(TW'(acc[ch]) - trial);
          q[ch][step] <= 1'b1;
        end
      end
    end
  end

  assign quot = {q[3], q[2], q[1], q[0]};

endmodule
`default_nettype wire
